// ----- src/tsz_pkg.sv -----
// ============================================================================
// tsz_pkg
// Shared types and constants for the zero in-degree topological sorter.
// ============================================================================
package tsz_pkg;

    localparam int unsigned MaxVertices = 64;
    localparam int unsigned VertW       = 6;
    localparam int unsigned CountW      = 7;

    localparam logic [1:0] CmdAdd   = 2'd0;
    localparam logic [1:0] CmdSort  = 2'd1;
    localparam logic [1:0] CmdClear = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [VertW-1:0] src_vertex;
        logic [VertW-1:0] dst_vertex;
    } t_in_req;

    typedef struct packed {
        logic [VertW-1:0] vertex;
        logic             ok;
        logic             last;
    } t_out_req;

    // Edge store access from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [VertW-1:0] wr_addr;
        logic [MaxVertices-1:0] wr_data;
        logic             rd_en;
        logic [VertW-1:0] rd_addr;
    } t_mem_ctl;

endpackage

// ----- src/topological_sort_zero_indegree.sv -----
// ============================================================================
// topological_sort_zero_indegree
// Kahn topological sort over a 64x64 adjacency row memory.
// ============================================================================
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    t_in_req
// out      out  o_out_valid / i_out_ready  t_out_req
// cfg      in   i_cfg_we                   i_cfg_data (vertex_count)
// An add reads the row, then writes it back with the new edge bit. Clear sweeps 64 rows.
// Reset clears the store by the same sweep; no request is taken then.
// Sort: in-degrees first (one row read a cycle), then per round a priority pick
// of the lowest zero in-degree vertex, one row read and an in-degree update.
// Results leave through an output register; a stall holds the sequencer.
// ============================================================================
module topological_sort_zero_indegree
    import tsz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_data,
    input  logic        i_cfg_we,
    input  logic [CountW-1:0] i_cfg_data
);

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_ARD   = 11'b00000000100,
        S_AWR   = 11'b00000001000,
        S_DRD   = 11'b00000010000,
        S_DACC  = 11'b00000100000,
        S_PICK  = 11'b00001000000,
        S_RRD   = 11'b00010000000,
        S_RUPD  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_FAIL  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [CountW-1:0] r_vcount;
    logic [CountW-1:0] r_cnt;
    logic [VertW-1:0]  r_src, r_dst;
    logic [CountW-1:0] r_indeg [MaxVertices];
    logic [MaxVertices-1:0] r_placed;
    logic [VertW-1:0]  r_order [MaxVertices];
    logic [CountW-1:0] r_placed_cnt;
    logic [CountW-1:0] r_rows_done;
    logic              r_out_valid;
    t_out_req          r_out;
    t_mem_ctl          s_ctl;
    logic [MaxVertices-1:0] s_row;
    logic [CountW-1:0] s_n;
    logic [MaxVertices-1:0] s_live;
    logic [MaxVertices-1:0] s_cand;
    logic              s_found;
    logic [VertW-1:0]  s_first;
    logic [VertW-1:0]  s_emit_idx;

    tsz_row_ram u_ram (
        .i_clk     (i_clk),
        .i_ctl     (s_ctl),
        .o_rd_data (s_row)
    );

    // Effective vertex count
    always_comb begin
        if (r_vcount == '0) begin
            s_n = CountW'(1);
        end else if (r_vcount > CountW'(MaxVertices)) begin
            s_n = CountW'(MaxVertices);
        end else begin
            s_n = r_vcount;
        end
    end

    always_comb begin
        for (int i = 0; i < MaxVertices; i++) begin
            s_live[i] = (CountW'(i) < s_n);
        end
    end

    // Lowest unplaced zero in-degree vertex
    always_comb begin
        s_found = 1'b0;
        s_first = '0;
        for (int i = 0; i < MaxVertices; i++) begin
            s_cand[i] = s_live[i] && !r_placed[i] && (r_indeg[i] == '0);
        end
        for (int i = MaxVertices - 1; i >= 0; i--) begin
            if (s_cand[i]) begin
                s_found = 1'b1;
                s_first = VertW'(i);
            end
        end
    end

    assign s_emit_idx = r_cnt[VertW-1:0];

    // Memory control
    always_comb begin
        s_ctl = '0;
        unique case (r_state)
            S_CLR: begin
                s_ctl.wr_en   = 1'b1;
                s_ctl.wr_addr = r_cnt[VertW-1:0];
            end
            S_IDLE: begin
                s_ctl.rd_en   = 1'b1;
                s_ctl.rd_addr = i_in_data.src_vertex;
            end
            S_AWR: begin
                s_ctl.wr_en   = 1'b1;
                s_ctl.wr_addr = r_src;
                s_ctl.wr_data = s_row | (MaxVertices'(1) << r_dst);
            end
            S_DRD, S_DACC: begin
                s_ctl.rd_en   = 1'b1;
                s_ctl.rd_addr = r_cnt[VertW-1:0];
            end
            S_PICK: begin
                s_ctl.rd_en   = 1'b1;
                s_ctl.rd_addr = s_first;
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_cnt == CountW'(MaxVertices - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.cmd)
                        CmdAdd:   n_state = S_ARD;
                        CmdSort:  n_state = S_DRD;
                        CmdClear: n_state = S_CLR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ARD:  n_state = S_AWR;
            S_AWR:  n_state = S_IDLE;
            S_DRD:  n_state = S_DACC;
            S_DACC: if (r_rows_done == s_n - CountW'(1)) n_state = S_PICK;
            S_PICK: begin
                if (r_placed_cnt == s_n) begin
                    n_state = S_EMIT;
                end else if (s_found) begin
                    n_state = S_RRD;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_RRD:  n_state = S_RUPD;
            S_RUPD: n_state = S_PICK;
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_cnt == s_n) n_state = S_IDLE;
                end
            end
            S_FAIL: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_vcount    <= CountW'(64);
            r_out_valid <= 1'b0;
            r_placed    <= '0;
            r_placed_cnt <= '0;
            r_rows_done <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vcount <= i_cfg_data;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: r_cnt <= (r_cnt == CountW'(MaxVertices - 1)) ? '0 : r_cnt + 1'b1;
                S_IDLE: begin
                    r_cnt        <= '0;
                    r_placed     <= '0;
                    r_placed_cnt <= '0;
                    r_rows_done  <= '0;
                end
                S_DRD:  r_cnt <= r_cnt + 1'b1;
                S_DACC: begin
                    r_cnt       <= r_cnt + 1'b1;
                    r_rows_done <= r_rows_done + 1'b1;
                end
                S_PICK: begin
                    r_cnt <= '0;
                    if (s_found && r_placed_cnt != s_n) begin
                        r_placed[s_first] <= 1'b1;
                        r_placed_cnt      <= r_placed_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        if (r_cnt != s_n) begin
                            r_out_valid <= 1'b1;
                            r_cnt       <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FAIL: if (!r_out_valid || i_out_ready) r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_src <= i_in_data.src_vertex;
                r_dst <= i_in_data.dst_vertex;
                for (int i = 0; i < MaxVertices; i++) r_indeg[i] <= '0;
            end
            S_DACC: begin
                // accumulate the row read last cycle
                for (int i = 0; i < MaxVertices; i++) begin
                    if (s_row[i] && s_live[i] && s_live[r_rows_done[VertW-1:0]])
                        r_indeg[i] <= r_indeg[i] + 1'b1;
                end
            end
            S_PICK: begin
                if (s_found && r_placed_cnt != s_n) begin
                    r_order[r_placed_cnt[VertW-1:0]] <= s_first;
                end
            end
            S_RUPD: begin
                for (int i = 0; i < MaxVertices; i++) begin
                    if (s_row[i] && s_live[i] && r_indeg[i] != '0)
                        r_indeg[i] <= r_indeg[i] - 1'b1;
                end
            end
            S_EMIT: begin
                if ((!r_out_valid || i_out_ready) && r_cnt != s_n) begin
                    r_out.vertex <= r_order[s_emit_idx];
                    r_out.ok     <= 1'b1;
                    r_out.last   <= (r_cnt + 1'b1 == s_n);
                end
            end
            S_FAIL: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.vertex <= '0;
                    r_out.ok     <= 1'b0;
                    r_out.last   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("request taken while busy");
    a_fail_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |-> o_out_data.last)
        else $error("cycle result without last");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_placed_cnt <= s_n)
        else $error("placed count overrun");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_placed_cnt == s_n))
        else $error("emit without full order");

endmodule

// ----- src/tsz_row_ram.sv -----
// ============================================================================
// tsz_row_ram
// Adjacency row memory, one write and one registered read per cycle.
// ============================================================================
module tsz_row_ram
    import tsz_pkg::*;
(
    input  logic                   i_clk,
    input  t_mem_ctl               i_ctl,
    output logic [MaxVertices-1:0] o_rd_data
);

    logic [MaxVertices-1:0] r_mem [MaxVertices];

    // Write row
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

endmodule

// ----- tb/tb_topological_sort_zero_indegree.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_topological_sort_zero_indegree
// Self-checking bench for the zero in-degree topological sorter: a directed
// table of edge loads, sorts and clears, then random graph sessions, every
// emitted vertex checked against a local model of Kahn's scheme.
// ============================================================================
module tb_topological_sort_zero_indegree;
    import tsz_pkg::*;

    // Command code with no function in the block
    localparam logic [1:0] CmdSpare = 2'd3;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_data;
    logic     i_cfg_we = 1'b0;
    logic [CountW-1:0] i_cfg_data = '0;

    topological_sort_zero_indegree dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model state
    logic [MaxVertices-1:0] adj_rows [MaxVertices];
    logic [CountW-1:0]      graph_size = 7'd64;
    t_out_req               order_q [$];
    int errors = 0, sorts_done = 0, cycles_seen = 0, results_seen = 0;

    function automatic int unsigned size_in_use();
        int unsigned n;
        n = graph_size;
        if (n == 0) n = 1;
        if (n > MaxVertices) n = MaxVertices;
        return n;
    endfunction

    // Kahn's scheme over the model's adjacency rows; queue the order it emits
    task automatic predict_order();
        int unsigned n, cnt;
        int deg [MaxVertices];
        bit placed [MaxVertices];
        int sorted [MaxVertices];
        t_out_req r;
        n = size_in_use();
        cnt = 0;
        for (int v = 0; v < n; v++) begin
            deg[v] = 0;
            placed[v] = 0;
            for (int u = 0; u < n; u++) if (adj_rows[u][v]) deg[v]++;
        end
        for (int rnd = 0; rnd < n; rnd++) begin
            for (int v = 0; v < n; v++) begin
                if (deg[v] == 0 && !placed[v]) begin
                    placed[v] = 1;
                    sorted[cnt++] = v;
                    for (int u = 0; u < n; u++)
                        if (adj_rows[v][u] && deg[u] > 0) deg[u]--;
                    break;
                end
            end
        end
        sorts_done++;
        if (cnt != n) begin
            cycles_seen++;
            r.vertex = '0; r.ok = 1'b0; r.last = 1'b1;
            order_q.push_back(r);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.vertex = sorted[i][VertW-1:0];
                r.ok = 1'b1;
                r.last = (i == n - 1);
                order_q.push_back(r);
            end
        end
    endtask

    task automatic apply_request(input t_in_req q);
        case (q.cmd)
            CmdAdd:   adj_rows[q.src_vertex][q.dst_vertex] = 1'b1;
            CmdSort:  predict_order();
            CmdClear: foreach (adj_rows[i]) adj_rows[i] = '0;
            default: ;
        endcase
    endtask

    // Send one request in bursts with random gaps; valid stays up inside a burst
    int burst_left = 0;
    task automatic send_request(input logic [1:0] c, input int s, input int d);
        t_in_req q;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        q.cmd = c; q.src_vertex = s[VertW-1:0]; q.dst_vertex = d[VertW-1:0];
        i_in_valid <= 1'b1;
        i_in_data  <= q;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(q);
    endtask

    // Hold until every expected result has come, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (order_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_size(input int v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[CountW-1:0];
        graph_size = v[CountW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: stall on a pattern of its own, check each accepted result
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (order_q.size() == 0) begin
                    $error("unexpected result vertex=%0d ok=%0b last=%0b",
                           o_out_data.vertex, o_out_data.ok, o_out_data.last);
                    errors++;
                end else begin
                    t_out_req e;
                    e = order_q.pop_front();
                    if (o_out_data.vertex !== e.vertex) begin
                        $error("vertex: expected %0d, got %0d", e.vertex, o_out_data.vertex);
                        errors++;
                    end
                    if (o_out_data.ok !== e.ok) begin
                        $error("ok: expected %0b, got %0b", e.ok, o_out_data.ok);
                        errors++;
                    end
                    if (o_out_data.last !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, o_out_data.last);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            i_out_ready <= (stall_phase < 9) ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Directed table: command, tail, head
    typedef struct { logic [1:0] c; int s; int d; } t_row;
    t_row dir_rows [] = '{
        '{CmdSort, 0, 0},       // empty graph, order 0..n-1
        '{CmdAdd, 2, 0}, '{CmdAdd, 1, 2}, '{CmdAdd, 1, 2},   // repeated edge
        '{CmdSort, 0, 0},
        '{CmdAdd, 3, 3},        // self loop
        '{CmdSort, 0, 0},
        '{CmdClear, 0, 0},
        '{CmdSpare, 63, 63},    // unused command
        '{CmdAdd, 63, 0}, '{CmdAdd, 0, 63},  // cycle at the extremes
        '{CmdSort, 0, 0},
        '{CmdClear, 0, 0},
        '{CmdAdd, 5, 1}, '{CmdAdd, 63, 63}, // edges beyond a small graph
        '{CmdSort, 0, 0}
    };

    initial begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset size, then sorts at a small size and out-of-range sizes
        foreach (dir_rows[i]) send_request(dir_rows[i].c, dir_rows[i].s, dir_rows[i].d);
        write_size(4);
        send_request(CmdSort, 0, 0);
        send_request(CmdClear, 0, 0);
        send_request(CmdSort, 0, 0);
        write_size(0);
        send_request(CmdSort, 0, 0);
        write_size(127);
        send_request(CmdSort, 0, 0);

        // Random sessions: clear, load mostly forward edges, sort
        for (int sess = 0; sess < 55; sess++) begin
            int n, k;
            n = (sess % 10 == 9) ? 64 : $urandom_range(1, 12);
            write_size((sess % 13 == 5) ? $urandom_range(65, 127) : n);
            n = size_in_use();
            send_request(CmdClear, 0, 0);
            k = $urandom_range(0, 14);
            for (int e = 0; e < k; e++) begin
                int a, b;
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if ($urandom_range(0, 9) == 0)
                    send_request(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                 $urandom_range(0, 63));
                else if ($urandom_range(0, 7) != 0 && a != b)
                    send_request(CmdAdd, (a < b) ? a : b, (a < b) ? b : a);
                else
                    send_request(CmdAdd, a, b);
            end
            send_request(CmdSort, 0, 0);
            if (sess % 8 == 3) drain();
        end
        drain();
        $display("Ran %0d sorts (%0d with a cycle), %0d results checked.",
                 sorts_done, cycles_seen, results_seen);
        $display("Graph sizes covered 1 to 64 including out-of-range settings.");
        if (errors == 0 && order_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/tsz_pkg.sv
src/tsz_row_ram.sv
src/topological_sort_zero_indegree.sv
tb/tb_topological_sort_zero_indegree.sv
